### rtl/cbie_pkg.sv
// Package for the CBOR item head encoder.
// Holds command codes, additional-info codes, widths and the queue entry type.
// No dependencies.
package cbie_pkg;

	localparam int MaxCapacity = 65536;
	localparam int CapW        = 17;
	localparam int FillW       = $clog2(MaxCapacity + 1);
	localparam int CmpW        = (FillW > CapW) ? FillW : CapW;
	localparam int PosW        = 16;
	localparam int ArgW        = 64;
	localparam int CntW        = 4;
	localparam logic [CapW-1:0] CapReset = CapW'(256);

	localparam logic [4:0] AiOneByte   = 5'd24;
	localparam logic [4:0] AiTwoBytes  = 5'd25;
	localparam logic [4:0] AiFourBytes = 5'd26;
	localparam logic [4:0] AiEightBytes = 5'd27;
	localparam logic [ArgW-1:0] InlineLimit = 64'd24;

	localparam logic [2:0] MajorUnsigned = 3'd0;
	localparam logic [2:0] MajorNegative = 3'd1;

	typedef enum logic [1:0] {
		CMD_HEAD  = 2'd0,
		CMD_INT   = 2'd1,
		CMD_BYTE  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEAD,
		ST_ARG
	} seq_state_t;

	typedef struct packed {
		logic            is_clear;
		logic [7:0]      lead;
		logic [CntW-1:0] nbytes;
		logic [ArgW-1:0] arg;
	} entry_t;

	typedef struct packed {
		logic can_push;
		logic has_item;
	} q_status_t;

endpackage

### rtl/cbie_front.sv
// Front end: accepts input items and turns each into a queue entry.
// Works out the lead byte, the argument byte count and a left-aligned argument.
// Depends on cbie_pkg.
module cbie_front (
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [2:0]                major_type,
	input  logic [63:0]               argument,
	input  logic [7:0]                payload_byte,
	input  cbie_pkg::q_status_t       q_status,
	output logic                      push,
	output cbie_pkg::entry_t          push_entry
);

	logic                          neg;
	logic [2:0]                    major;
	logic [cbie_pkg::ArgW-1:0]     arg;
	cbie_pkg::entry_t              head;

	assign in_ready = q_status.can_push;
	assign push     = in_valid && q_status.can_push;

	always_comb begin
		neg   = (cbie_pkg::cmd_t'(command) == cbie_pkg::CMD_INT) && argument[63];
		major = major_type;
		if (cbie_pkg::cmd_t'(command) == cbie_pkg::CMD_INT) begin
			major = neg ? cbie_pkg::MajorNegative : cbie_pkg::MajorUnsigned;
		end
		arg = neg ? ~argument : argument;

		head.is_clear = 1'b0;
		if (arg < cbie_pkg::InlineLimit) begin
			head.lead   = {major, arg[4:0]};
			head.nbytes = cbie_pkg::CntW'(0);
			head.arg    = '0;
		end else if (arg[63:8] == '0) begin
			head.lead   = {major, cbie_pkg::AiOneByte};
			head.nbytes = cbie_pkg::CntW'(1);
			head.arg    = {arg[7:0], 56'd0};
		end else if (arg[63:16] == '0) begin
			head.lead   = {major, cbie_pkg::AiTwoBytes};
			head.nbytes = cbie_pkg::CntW'(2);
			head.arg    = {arg[15:0], 48'd0};
		end else if (arg[63:32] == '0) begin
			head.lead   = {major, cbie_pkg::AiFourBytes};
			head.nbytes = cbie_pkg::CntW'(4);
			head.arg    = {arg[31:0], 32'd0};
		end else begin
			head.lead   = {major, cbie_pkg::AiEightBytes};
			head.nbytes = cbie_pkg::CntW'(8);
			head.arg    = arg;
		end

		case (cbie_pkg::cmd_t'(command))
			cbie_pkg::CMD_HEAD, cbie_pkg::CMD_INT: begin
				push_entry = head;
			end
			cbie_pkg::CMD_BYTE: begin
				push_entry.is_clear = 1'b0;
				push_entry.lead     = payload_byte;
				push_entry.nbytes   = '0;
				push_entry.arg      = '0;
			end
			default: begin
				push_entry.is_clear = 1'b1;
				push_entry.lead     = '0;
				push_entry.nbytes   = '0;
				push_entry.arg      = '0;
			end
		endcase
	end

endmodule

### rtl/cbie_queue.sv
// Two-entry queue between the front end and the byte sequencer.
// Depends on cbie_pkg for the entry and status types.
module cbie_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbie_pkg::entry_t    push_entry,
	input  logic                pop,
	output cbie_pkg::entry_t    head_entry,
	output cbie_pkg::q_status_t q_status
);

	cbie_pkg::entry_t mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	assign q_status.can_push = (count_q != 2'd2);
	assign q_status.has_item = (count_q != 2'd0);
	assign head_entry        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> count_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 && !push) |=> count_q == 2'd0)
		else $error("empty queue gained an entry");

endmodule

### rtl/cbie_back.sv
// Byte sequencer: takes an entry only when idle, then emits its bytes.
// Keeps the capacity register, the fill offset and the output register.
// Depends on cbie_pkg.
module cbie_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cbie_pkg::CapW-1:0]  cfg_data,
	input  cbie_pkg::q_status_t        q_status,
	input  cbie_pkg::entry_t           head_entry,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       stored,
	output logic [15:0]                write_position,
	output logic                       last_of_item
);

	cbie_pkg::seq_state_t           state_q, state_d;
	logic [cbie_pkg::CapW-1:0]      cap_q;
	logic [cbie_pkg::FillW-1:0]     fill_q;
	logic [7:0]                     lead_q;
	logic [cbie_pkg::ArgW-1:0]      arg_q;
	logic [cbie_pkg::CntW-1:0]      rem_q;
	logic                           ov_q;
	logic [7:0]                     ob_q;
	logic                           os_q;
	logic [cbie_pkg::PosW-1:0]      op_q;
	logic                           ol_q;

	logic                           slot_free;
	logic                           load;
	logic                           do_clear;
	logic                           emit_fire;
	logic [7:0]                     emit_byte;
	logic                           emit_last;
	logic [cbie_pkg::CmpW-1:0]      cap_ext;
	logic [cbie_pkg::CmpW-1:0]      cap_eff;
	logic                           room;

	assign cfg_ready      = 1'b1;
	assign out_valid      = ov_q;
	assign out_byte       = ob_q;
	assign stored         = os_q;
	assign write_position = op_q;
	assign last_of_item   = ol_q;
	assign slot_free      = !ov_q || out_ready;

	assign cap_ext = cbie_pkg::CmpW'(cap_q);
	assign cap_eff = (cap_ext > cbie_pkg::CmpW'(cbie_pkg::MaxCapacity))
		? cbie_pkg::CmpW'(cbie_pkg::MaxCapacity) : cap_ext;
	assign room    = cbie_pkg::CmpW'(fill_q) < cap_eff;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbie_pkg::ST_IDLE: begin
				if (q_status.has_item && !head_entry.is_clear) begin
					state_d = cbie_pkg::ST_LEAD;
				end
			end
			cbie_pkg::ST_LEAD: begin
				if (slot_free) begin
					state_d = (rem_q == '0) ? cbie_pkg::ST_IDLE : cbie_pkg::ST_ARG;
				end
			end
			cbie_pkg::ST_ARG: begin
				if (slot_free && rem_q == cbie_pkg::CntW'(1)) begin
					state_d = cbie_pkg::ST_IDLE;
				end
			end
			default: state_d = cbie_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		do_clear  = 1'b0;
		emit_fire = 1'b0;
		emit_byte = lead_q;
		emit_last = 1'b0;
		case (state_q)
			cbie_pkg::ST_IDLE: begin
				pop      = q_status.has_item;
				load     = q_status.has_item && !head_entry.is_clear;
				do_clear = q_status.has_item && head_entry.is_clear;
			end
			cbie_pkg::ST_LEAD: begin
				emit_fire = slot_free;
				emit_byte = lead_q;
				emit_last = (rem_q == '0);
			end
			cbie_pkg::ST_ARG: begin
				emit_fire = slot_free;
				emit_byte = arg_q[63:56];
				emit_last = (rem_q == cbie_pkg::CntW'(1));
			end
			default: begin
				emit_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lead_q <= head_entry.lead;
			arg_q  <= head_entry.arg;
			rem_q  <= head_entry.nbytes;
		end else if (emit_fire && state_q == cbie_pkg::ST_ARG) begin
			arg_q <= {arg_q[55:0], 8'd0};
			rem_q <= rem_q - cbie_pkg::CntW'(1);
		end
		if (emit_fire) begin
			ob_q <= emit_byte;
			os_q <= room;
			op_q <= room ? cbie_pkg::PosW'(fill_q) : '0;
			ol_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbie_pkg::ST_IDLE;
			cap_q   <= cbie_pkg::CapReset;
			fill_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (do_clear) begin
				fill_q <= '0;
			end else if (emit_fire && room) begin
				fill_q <= fill_q + cbie_pkg::FillW'(1);
			end
			if (emit_fire) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cbie_pkg::CmpW'(fill_q) <= cbie_pkg::CmpW'(cbie_pkg::MaxCapacity))
		else $error("fill offset beyond capacity limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && emit_last |=> state_q == cbie_pkg::ST_IDLE)
		else $error("sequencer busy after last byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == cbie_pkg::ST_IDLE)
		else $error("entry taken while sequencer busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && room && !do_clear) |=> fill_q == $past(fill_q) + cbie_pkg::FillW'(1))
		else $error("fill offset did not advance on stored byte");

endmodule

### rtl/cbor_item_head_encoder.sv
// Top level of the CBOR item head encoder.
// Depends on cbie_pkg, cbie_front, cbie_queue and cbie_back.
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    command, major_type, argument, payload_byte
// out      source     out_valid / out_ready  out_byte, stored, write_position, last_of_item
// cfg      sink       cfg_valid / cfg_ready  cfg_data (buffer capacity)
//
// The sequencer takes an item's entry from the queue while it is idle, then emits
// the lead byte followed by any argument bytes.
// A clear item is taken while the sequencer is idle and emits nothing.
// The two-entry queue lets input items be taken while the sequencer is busy.
// out_ready low while out_valid is high holds the output register and stalls the sequencer.
// Reset sets capacity to 256 and the fill offset to zero; cfg_ready is always high.
module cbor_item_head_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [2:0]  major_type,
	input  logic [63:0] argument,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        stored,
	output logic [15:0] write_position,
	output logic        last_of_item
);

	cbie_pkg::q_status_t q_status;
	cbie_pkg::entry_t    push_entry;
	cbie_pkg::entry_t    head_entry;
	logic                push;
	logic                pop;

	cbie_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.major_type   (major_type),
		.argument     (argument),
		.payload_byte (payload_byte),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	cbie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.q_status   (q_status)
	);

	cbie_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.q_status       (q_status),
		.head_entry     (head_entry),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.stored         (stored),
		.write_position (write_position),
		.last_of_item   (last_of_item)
	);

endmodule

### bench/tb_top.sv
// Self-checking bench for cbor_item_head_encoder: the encoded bytes are predicted
// from each accepted command and compared field by field as they leave the block.
// Depends on cbie_pkg and the cbor_item_head_encoder RTL.
`timescale 1ns / 1ps

module tb_top;
	import cbie_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int SettleCycles  = 12;
	localparam int LongHold      = 100;

	typedef struct packed {
		cmd_t        op;
		logic [2:0]  maj;
		logic [63:0] arg;
		logic [7:0]  pb;
	} cbor_cmd_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        kept;
		logic [15:0] pos;
		logic        last;
	} enc_byte_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = '0;
	logic [2:0]  major_type = '0;
	logic [63:0] argument = '0;
	logic [7:0]  payload_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        stored;
	logic [15:0] write_position;
	logic        last_of_item;

	cbor_cmd_t queued_commands[$];
	enc_byte_t expected_bytes[$];
	logic [16:0] buffer_limit = CapReset;
	logic [16:0] fill_level = '0;

	int errors = 0;
	int cmds_taken = 0;
	int bytes_seen = 0;
	int bytes_dropped = 0;
	int capacity_writes = 0;
	int in_gap = 0;
	int out_stall = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	cbor_cmd_t next_cmd;
	enc_byte_t want;

	cbor_item_head_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.major_type    (major_type),
		.argument      (argument),
		.payload_byte  (payload_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.stored        (stored),
		.write_position(write_position),
		.last_of_item  (last_of_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void add_expected(logic [7:0] b, logic last);
		enc_byte_t e;
		logic [16:0] lim;
		lim = (buffer_limit > MaxCapacity) ? 17'(MaxCapacity) : buffer_limit;
		e.data = b;
		e.last = last;
		if (fill_level < lim) begin
			e.kept = 1'b1;
			e.pos = fill_level[15:0];
			fill_level = fill_level + 1'b1;
		end else begin
			e.kept = 1'b0;
			e.pos = '0;
		end
		expected_bytes.push_back(e);
	endfunction

	function automatic void predict_head(logic [2:0] maj, logic [63:0] arg);
		logic [7:0] lead;
		int nb;
		lead = {maj, 5'd0};
		nb = 0;
		if (arg < InlineLimit) begin
			nb = 0;
		end else if (arg < 64'd256) begin
			lead[4:0] = AiOneByte;
			nb = 1;
		end else if (arg < 64'd65536) begin
			lead[4:0] = AiTwoBytes;
			nb = 2;
		end else if (arg < 64'h1_0000_0000) begin
			lead[4:0] = AiFourBytes;
			nb = 4;
		end else begin
			lead[4:0] = AiEightBytes;
			nb = 8;
		end
		if (nb == 0) begin
			add_expected(lead | arg[7:0], 1'b1);
		end else begin
			add_expected(lead, 1'b0);
			for (int k = nb - 1; k >= 0; k--)
				add_expected(arg[8*k +: 8], k == 0);
		end
	endfunction

	function automatic void predict_encoding(cmd_t op, logic [2:0] maj, logic [63:0] arg,
			logic [7:0] pb);
		case (op)
			CMD_HEAD: predict_head(maj, arg);
			CMD_INT: begin
				if (arg[63])
					predict_head(MajorNegative, ~arg);
				else
					predict_head(MajorUnsigned, arg);
			end
			CMD_BYTE: add_expected(pb, 1'b1);
			default: fill_level = '0;
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endfunction

	function automatic cbor_cmd_t mk(cmd_t op, logic [2:0] maj, logic [63:0] arg,
			logic [7:0] pb);
		cbor_cmd_t c;
		c.op = op;
		c.maj = maj;
		c.arg = arg;
		c.pb = pb;
		return c;
	endfunction

	function automatic logic [63:0] pick_arg();
		case ($urandom_range(0, 7))
			0: return 64'($urandom_range(0, 23));
			1: return 64'($urandom_range(24, 255));
			2: return 64'($urandom_range(256, 65535));
			3: return {32'd0, 32'($urandom_range(32'hFFFF_FFFF, 32'h1_0000))};
			4: return {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)};
			5: return ~64'($urandom_range(0, 300));
			6: begin
				case ($urandom_range(0, 7))
					0: return 64'd23;
					1: return 64'd24;
					2: return 64'd255;
					3: return 64'd256;
					4: return 64'd65535;
					5: return 64'd65536;
					6: return 64'hFFFF_FFFF;
					default: return 64'h1_0000_0000;
				endcase
			end
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Strings (length head then content), some truncated, mixed with loose items.
	task automatic queue_random(int n);
		int made;
		int kind;
		int len;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 19);
			if (kind < 8) begin
				len = $urandom_range(0, 6);
				queued_commands.push_back(mk(CMD_HEAD, 3'($urandom_range(2, 3)), 64'(len),
					8'($urandom)));
				if (kind == 0)
					len = $urandom_range(0, len);
				repeat (len)
					queued_commands.push_back(mk(CMD_BYTE, 3'($urandom),
						{32'($urandom), 32'($urandom)}, 8'($urandom)));
				made += 1 + len;
			end else if (kind < 12) begin
				queued_commands.push_back(mk(CMD_INT, 3'($urandom), pick_arg(), 8'($urandom)));
				made++;
			end else if (kind < 17) begin
				queued_commands.push_back(mk(CMD_HEAD, 3'($urandom), pick_arg(), 8'($urandom)));
				made++;
			end else if (kind < 19) begin
				queued_commands.push_back(mk(CMD_BYTE, 3'($urandom),
					{32'($urandom), 32'($urandom)}, 8'($urandom)));
				made++;
			end else begin
				queued_commands.push_back(mk(CMD_CLEAR, 3'($urandom),
					{32'($urandom), 32'($urandom)}, 8'($urandom)));
				made++;
			end
		end
	endtask

	task automatic wait_until_quiet();
		do @(posedge clk);
		while (queued_commands.size() != 0 || in_valid || expected_bytes.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_capacity(logic [16:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		buffer_limit = value;
		capacity_writes++;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_encoding(cmd_t'(command), major_type, argument, payload_byte);
				cmds_taken++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (queued_commands.size() != 0) begin
					next_cmd = queued_commands.pop_front();
					command <= next_cmd.op;
					major_type <= next_cmd.maj;
					argument <= next_cmd.arg;
					payload_byte <= next_cmd.pb;
					in_valid <= 1'b1;
					in_gap = ((cmds_taken / 32) % 3 == 0) ? 0 : $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				bytes_seen++;
				if (!stored)
					bytes_dropped++;
				if (expected_bytes.size() == 0) begin
					errors++;
					$display("%0t: byte %0h arrived, expected nothing", $time, out_byte);
				end else begin
					want = expected_bytes.pop_front();
					check_field("out_byte", 16'(want.data), 16'(out_byte));
					check_field("stored", 16'(want.kept), 16'(stored));
					check_field("write_position", want.pos, write_position);
					check_field("last_of_item", 16'(want.last), 16'(last_of_item));
				end
				out_stall = (bytes_seen % 128 < 40) ? 0 : $urandom_range(0, 7);
				if (bytes_seen == 150 || bytes_seen == 700)
					hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (arst_n && quiet_cycles >= WatchdogLimit) begin
			$display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
			$display("cbor_item_head_encoder test failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queued_commands.push_back(mk(CMD_HEAD, 3'd0, 64'd0, 8'h5A));
		queued_commands.push_back(mk(CMD_HEAD, 3'd1, 64'd23, 8'h00));
		queued_commands.push_back(mk(CMD_HEAD, 3'd2, 64'd24, 8'hFF));
		queued_commands.push_back(mk(CMD_HEAD, 3'd3, 64'd255, 8'h11));
		queued_commands.push_back(mk(CMD_HEAD, 3'd4, 64'd256, 8'h22));
		queued_commands.push_back(mk(CMD_HEAD, 3'd5, 64'd65535, 8'h33));
		queued_commands.push_back(mk(CMD_HEAD, 3'd6, 64'd65536, 8'h44));
		queued_commands.push_back(mk(CMD_HEAD, 3'd7, 64'hFFFF_FFFF, 8'h55));
		queued_commands.push_back(mk(CMD_HEAD, 3'd0, 64'h1_0000_0000, 8'h66));
		queued_commands.push_back(mk(CMD_HEAD, 3'd7, '1, 8'h77));
		queued_commands.push_back(mk(CMD_INT, 3'd7, 64'd0, 8'h88));
		queued_commands.push_back(mk(CMD_INT, 3'd5, 64'h7FFF_FFFF_FFFF_FFFF, 8'h99));
		queued_commands.push_back(mk(CMD_INT, 3'd2, '1, 8'hAA));
		queued_commands.push_back(mk(CMD_INT, 3'd0, 64'h8000_0000_0000_0000, 8'hBB));
		queued_commands.push_back(mk(CMD_INT, 3'd3, -64'sd24, 8'hCC));
		queued_commands.push_back(mk(CMD_INT, 3'd4, -64'sd25, 8'hDD));
		queued_commands.push_back(mk(CMD_BYTE, 3'd7, '1, 8'h00));
		queued_commands.push_back(mk(CMD_BYTE, 3'd0, '0, 8'hFF));
		queued_commands.push_back(mk(CMD_CLEAR, 3'd6, 64'h0123_4567_89AB_CDEF, 8'hEE));
		queued_commands.push_back(mk(CMD_BYTE, 3'd1, 64'd5, 8'hA5));
		queued_commands.push_back(mk(CMD_INT, 3'd1, -64'sd257, 8'h3C));
		wait_until_quiet();

		// above the limit, so acts as the largest buffer
		write_capacity(17'h1FFFF);
		queue_random(80);
		wait_until_quiet();

		// lowered under the fill level: drop until cleared
		write_capacity(17'd20);
		queue_random(60);
		wait_until_quiet();

		write_capacity(17'd0);
		queue_random(30);
		wait_until_quiet();

		write_capacity(17'd1);
		queued_commands.push_back(mk(CMD_CLEAR, 3'd0, '0, 8'h00));
		queue_random(40);
		wait_until_quiet();

		write_capacity(17'(MaxCapacity));
		queue_random(60);
		wait_until_quiet();

		write_capacity(17'd300);
		queue_random(40);
		wait_until_quiet();

		$display("Ran %0d commands through %0d capacity writes; %0d bytes checked, %0d dropped.",
			cmds_taken, capacity_writes, bytes_seen, bytes_dropped);
		if (errors == 0)
			$display("cbor_item_head_encoder test passed");
		else
			$display("cbor_item_head_encoder test failed");
		$finish;
	end

endmodule
